>>> design/rsb_pkg.sv
// ---------------------------------------------------------------------------
// rsb_pkg: shared types and constants of the run-length sprite blitter
// Code byte values, draw mode codes, field widths and the beat structs that
// pass between the blitter modules.
// ---------------------------------------------------------------------------
package rsb_pkg;

    localparam int CURSOR_W = 26;
    localparam int COLUMN_W = 13;
    localparam int ROWW_W   = 12;
    localparam int CFG_W    = 13;
    localparam int ADDR_W   = 24;
    localparam int COORD_W  = 13;

    localparam logic [CFG_W-1:0] PITCH_RESET  = 13'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd200;

    localparam logic       REG_LINE_PITCH     = 1'b0;
    localparam logic       REG_SURFACE_HEIGHT = 1'b1;

    localparam logic       OP_START = 1'b0;
    localparam logic       OP_CODE  = 1'b1;

    localparam logic [7:0] CODE_SKIP    = 8'd255;
    localparam logic [7:0] CODE_ROW_END = 8'd254;
    localparam logic [7:0] CODE_GAP     = 8'd253;

    localparam logic [7:0] HV_OVER_LIMIT = 8'h1f;
    localparam logic [7:0] NIBBLE_MAX    = 8'h0f;

    localparam logic [2:0] MODE_COPY      = 3'd0;
    localparam logic [2:0] MODE_BLEND     = 3'd1;
    localparam logic [2:0] MODE_HV_UNSAFE = 3'd2;
    localparam logic [2:0] MODE_HV        = 3'd3;
    localparam logic [2:0] MODE_HV_BLEND  = 3'd4;
    localparam logic [2:0] MODE_DARKEN    = 3'd5;
    localparam logic [2:0] MODE_BLACK     = 3'd6;

    typedef struct packed {
        logic                       op;
        logic [7:0]                 code;
        logic [7:0]                 dest_pixel;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic [ROWW_W-1:0]          sprite_width;
        logic [2:0]                 mode;
        logic [3:0]                 hue;
        logic signed [7:0]          value;
    } in_beat_t;

    typedef struct packed {
        logic                       write_enable;
        logic [ADDR_W-1:0]          write_address;
        logic [7:0]                 write_data;
        logic signed [CURSOR_W-1:0] next_address;
        logic                       stopped;
    } result_t;

endpackage

>>> design/rsb_shade.sv
// ---------------------------------------------------------------------------
// rsb_shade: pixel shading
// Forms the palette byte of one drawn pixel from the code byte, the
// destination byte and the latched mode, hue and brightness offset.
// ---------------------------------------------------------------------------
module rsb_shade
    import rsb_pkg::*;
(
    input  logic [7:0] code,
    input  logic [7:0] dest_pixel,
    input  logic [2:0] draw_mode,
    input  logic [3:0] hue_nibble,
    input  logic [7:0] bright_offset,
    output logic [7:0] pixel
);

    logic [7:0] t_raw;
    logic [3:0] t_clamp;
    logic [4:0] blend_sum;
    logic [4:0] hv_blend_sum;

    always_comb begin
        t_raw = {4'h0, code[3:0]} + bright_offset;
        if (t_raw > NIBBLE_MAX) begin
            t_clamp = (t_raw >= HV_OVER_LIMIT) ? 4'h0 : 4'hf;
        end else begin
            t_clamp = t_raw[3:0];
        end
        blend_sum    = {1'b0, dest_pixel[3:0]} + {1'b0, code[3:0]};
        hv_blend_sum = {1'b0, dest_pixel[3:0]} + {1'b0, t_clamp};
    end

    always_comb begin
        case (draw_mode)
            MODE_BLEND:     pixel = {code[7:4], blend_sum[4:1]};
            MODE_HV_UNSAFE: pixel = {hue_nibble, 4'h0} | t_raw;
            MODE_HV:        pixel = {hue_nibble, t_clamp};
            MODE_HV_BLEND:  pixel = {hue_nibble, hv_blend_sum[4:1]};
            MODE_DARKEN:    pixel = {dest_pixel[7:4], 1'b0, dest_pixel[3:1]};
            MODE_BLACK:     pixel = 8'h00;
            default:        pixel = code;
        endcase
    end

endmodule

>>> design/rsb_engine.sv
// ---------------------------------------------------------------------------
// rsb_engine: cursor and sprite state
// Holds the cursor, column and latched sprite settings, decodes each code
// byte and forms the result of every accepted beat in the same cycle.
// ---------------------------------------------------------------------------
module rsb_engine
    import rsb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  in_beat_t            beat,
    input  logic [CFG_W-1:0]    line_pitch,
    input  logic [CURSOR_W-1:0] limit,
    output result_t             result
);

    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [COLUMN_W-1:0] column_reg, column_next;
    logic [ROWW_W-1:0]   row_width_reg;
    logic [2:0]          draw_mode_reg;
    logic [3:0]          hue_nibble_reg;
    logic [7:0]          bright_offset_reg;
    logic                count_pending_reg, count_pending_next;
    logic                halted_reg, halted_next;

    logic signed [2*COORD_W:0] start_prod;
    logic [CURSOR_W-1:0]       start_cursor;
    logic [7:0]                step;
    logic [COLUMN_W-1:0]       col_sum;
    logic [CURSOR_W-1:0]       cursor_row_end;
    logic                      at_limit;
    logic [7:0]                pixel;

    rsb_shade u_shade (
        .code          (beat.code),
        .dest_pixel    (beat.dest_pixel),
        .draw_mode     (draw_mode_reg),
        .hue_nibble    (hue_nibble_reg),
        .bright_offset (bright_offset_reg),
        .pixel         (pixel)
    );

    always_comb begin
        start_prod   = beat.start_y * $signed({1'b0, line_pitch});
        start_cursor = start_prod[CURSOR_W-1:0]
                     + {{(CURSOR_W-COORD_W){beat.start_x[COORD_W-1]}}, beat.start_x};
        step         = count_pending_reg ? beat.code : 8'd1;
        col_sum      = column_reg + {{(COLUMN_W-8){1'b0}}, step};
        cursor_row_end = cursor_reg + {{(CURSOR_W-CFG_W){1'b0}}, line_pitch}
                       - {{(CURSOR_W-COLUMN_W){1'b0}}, column_reg};
        at_limit = !cursor_reg[CURSOR_W-1]
                 && ({1'b0, cursor_reg[CURSOR_W-2:0]} >= limit);
    end

    always_comb begin
        cursor_next        = cursor_reg;
        column_next        = column_reg;
        count_pending_next = count_pending_reg;
        halted_next        = halted_reg;
        result             = '0;
        if (beat.op == OP_START) begin
            cursor_next        = start_cursor;
            column_next        = '0;
            count_pending_next = 1'b0;
            halted_next        = 1'b0;
        end else if (!halted_reg) begin
            if (!count_pending_reg && beat.code == CODE_SKIP) begin
                count_pending_next = 1'b1;
            end else if (!count_pending_reg && beat.code == CODE_ROW_END) begin
                cursor_next = cursor_row_end;
                column_next = '0;
            end else if (!count_pending_reg && beat.code != CODE_GAP && at_limit) begin
                halted_next = 1'b1;
            end else begin
                if (!count_pending_reg && beat.code != CODE_GAP
                    && !cursor_reg[CURSOR_W-1]) begin
                    result.write_enable  = 1'b1;
                    result.write_address = cursor_reg[ADDR_W-1:0];
                    result.write_data    = pixel;
                end
                count_pending_next = 1'b0;
                if (col_sum >= {1'b0, row_width_reg}) begin
                    cursor_next = cursor_row_end;
                    column_next = '0;
                end else begin
                    cursor_next = cursor_reg + {{(CURSOR_W-8){1'b0}}, step};
                    column_next = col_sum;
                end
            end
        end
        result.next_address = cursor_next;
        result.stopped      = halted_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg        <= '0;
            column_reg        <= '0;
            row_width_reg     <= '0;
            draw_mode_reg     <= MODE_COPY;
            hue_nibble_reg    <= '0;
            bright_offset_reg <= '0;
            count_pending_reg <= 1'b0;
            halted_reg        <= 1'b1;
        end else if (accept) begin
            cursor_reg        <= cursor_next;
            column_reg        <= column_next;
            count_pending_reg <= count_pending_next;
            halted_reg        <= halted_next;
            if (beat.op == OP_START) begin
                row_width_reg     <= beat.sprite_width;
                draw_mode_reg     <= beat.mode;
                hue_nibble_reg    <= beat.hue;
                bright_offset_reg <= beat.value;
            end
        end
    end

endmodule

>>> design/rle_sprite_blitter.sv
// ---------------------------------------------------------------------------
// rle_sprite_blitter: run-length sprite blitter
// Decodes a stream of run-length sprite code bytes into framebuffer byte
// writes with palette shading, one result beat per input beat.
//
// Channel   Direction  tdata / tuser
// s_axis    in         tuser: op; tdata: code..value (69 bits in 72)
// m_axis    out        tdata: write_enable..stopped (60 bits in 64)
// cfg       in         write enable, 1-bit index, 13-bit data
//
// Every input beat is decoded in the cycle it is accepted; its result beat
// appears in the output register on the next cycle, one beat per cycle while m_axis_tready is high.
// The output register stalls on m_axis_tready and s_axis_tready follows it.
// Reset leaves the blitter halted until a start beat arrives.
// ---------------------------------------------------------------------------
module rle_sprite_blitter
    import rsb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] code, [15:8] dest_pixel, [28:16] start_x, [41:29] start_y,
    // [53:42] sprite_width, [56:54] mode, [60:57] hue, [68:61] value
    input  logic [71:0]      s_axis_tdata,
    // [0] op
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [0] write_enable, [24:1] write_address, [32:25] write_data,
    // [58:33] next_address, [59] stopped
    output logic [63:0]      m_axis_tdata,
    input  logic             cfg_wr_en,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [CFG_W-1:0]    line_pitch_reg, line_pitch_next;
    logic [CFG_W-1:0]    surface_height_reg, surface_height_next;
    logic [CURSOR_W-1:0] limit_reg;
    logic                m_valid_reg;
    result_t             m_data_reg;
    in_beat_t            beat;
    result_t             result;
    logic                accept;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        beat.op           = s_axis_tuser;
        beat.code         = s_axis_tdata[7:0];
        beat.dest_pixel   = s_axis_tdata[15:8];
        beat.start_x      = s_axis_tdata[28:16];
        beat.start_y      = s_axis_tdata[41:29];
        beat.sprite_width = s_axis_tdata[53:42];
        beat.mode         = s_axis_tdata[56:54];
        beat.hue          = s_axis_tdata[60:57];
        beat.value        = s_axis_tdata[68:61];
    end

    always_comb begin
        line_pitch_next     = line_pitch_reg;
        surface_height_next = surface_height_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LINE_PITCH:     line_pitch_next     = cfg_wdata;
                REG_SURFACE_HEIGHT: surface_height_next = cfg_wdata;
                default:            line_pitch_next     = line_pitch_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_pitch_reg     <= PITCH_RESET;
            surface_height_reg <= HEIGHT_RESET;
            limit_reg          <= CURSOR_W'(PITCH_RESET * HEIGHT_RESET);
        end else begin
            line_pitch_reg     <= line_pitch_next;
            surface_height_reg <= surface_height_next;
            limit_reg          <= CURSOR_W'(line_pitch_next * surface_height_next);
        end
    end

    rsb_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .beat       (beat),
        .line_pitch (line_pitch_reg),
        .limit      (limit_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'h0, m_data_reg.stopped, m_data_reg.next_address,
                            m_data_reg.write_data, m_data_reg.write_address,
                            m_data_reg.write_enable};

endmodule
